[design/lc3_pkg.sv]
// Package: request codes, opcodes, trap vectors, sequencer states and helper functions.
package lc3_pkg;

    localparam logic [2:0] REQ_STEP   = 3'd0;
    localparam logic [2:0] REQ_MEM_WR = 3'd1;
    localparam logic [2:0] REQ_MEM_RD = 3'd2;
    localparam logic [2:0] REQ_REG_WR = 3'd3;
    localparam logic [2:0] REQ_PC_WR  = 3'd4;

    localparam logic [3:0] OP_BR   = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_LD   = 4'd2;
    localparam logic [3:0] OP_ST   = 4'd3;
    localparam logic [3:0] OP_JSR  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_LDR  = 4'd6;
    localparam logic [3:0] OP_STR  = 4'd7;
    localparam logic [3:0] OP_NOT  = 4'd9;
    localparam logic [3:0] OP_LDI  = 4'd10;
    localparam logic [3:0] OP_STI  = 4'd11;
    localparam logic [3:0] OP_JMP  = 4'd12;
    localparam logic [3:0] OP_LEA  = 4'd14;
    localparam logic [3:0] OP_TRAP = 4'd15;

    localparam logic [7:0] TRAP_GETC = 8'h20;
    localparam logic [7:0] TRAP_OUT  = 8'h21;
    localparam logic [7:0] TRAP_PUTS = 8'h22;
    localparam logic [7:0] TRAP_IN   = 8'h23;

    localparam logic [15:0] RESET_PC  = 16'h3000;
    localparam logic [15:0] ADDR_KBD  = 16'hFFFD;
    localparam logic [15:0] ADDR_PUTS = 16'hFFFE;
    localparam logic [15:0] ADDR_OUT  = 16'hFFFF;
    localparam logic [2:0]  NZP_ZERO  = 3'b010;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_DECODE,
        ST_RDA,
        ST_RDB,
        ST_EXEC,
        ST_LOAD,
        ST_LOAD2,
        ST_DONE
    } state_t;

    function automatic logic [2:0] nzp_of(input logic [15:0] v);
        logic [2:0] f;
        begin
            if (v[15])
                f = 3'b100;
            else if (v == 16'd0)
                f = 3'b010;
            else
                f = 3'b001;
            return f;
        end
    endfunction

    function automatic logic [15:0] sext5(input logic [15:0] ins);
        return {{11{ins[4]}}, ins[4:0]};
    endfunction

    function automatic logic [15:0] sext6(input logic [15:0] ins);
        return {{10{ins[5]}}, ins[5:0]};
    endfunction

    function automatic logic [15:0] sext9(input logic [15:0] ins);
        return {{7{ins[8]}}, ins[8:0]};
    endfunction

    function automatic logic [15:0] sext11(input logic [15:0] ins);
        return {{5{ins[10]}}, ins[10:0]};
    endfunction

endpackage

[design/lc3_if.sv]
// Interfaces: request and response channels with valid/ready handshake.
interface lc3_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] address;
    logic [2:0]  reg_index;
    logic [15:0] write_value;

    modport source (output valid, output req_type, output address, output reg_index,
                    output write_value, input ready);
    modport sink   (input valid, input req_type, input address, input reg_index,
                    input write_value, output ready);
endinterface

interface lc3_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic [15:0] pc_now;
    logic        flag_n;
    logic        flag_z;
    logic        flag_p;
    logic        halt_seen;

    modport source (output valid, output read_data, output pc_now, output flag_n,
                    output flag_z, output flag_p, output halt_seen, input ready);
    modport sink   (input valid, input read_data, input pc_now, input flag_n,
                    input flag_z, input flag_p, input halt_seen, output ready);
endinterface

[design/lc3_instruction_core_unit.sv]
// Top level: multicycle LC-3 core with shared adder, sequencer and word memory.
//
//  channel | role   | payload
//  req     | sink   | req_type, address, reg_index, write_value
//  rsp     | source | read_data, pc_now, flag_n, flag_z, flag_p, halt_seen
//
// After reset a clearing pass zeroes memory, one word a cycle, across all 2^ADDR_BITS words,
// with req.ready low. A step goes from accept to response load through fetch, decode,
// two register reads, execute and up to two dependent memory reads; other requests
// skip these. The single memory port and the shared adder set this sequencing.
// A held response does not block acceptance of the next request.
module lc3_instruction_core_unit #(
    parameter int ADDR_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    lc3_req_if.sink     req,
    lc3_rsp_if.source   rsp
);

    localparam int DEPTH = 1 << ADDR_BITS;

    lc3_pkg::state_t state_reg, state_next;
    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic [2:0]  rt_reg, rt_next;
    logic [15:0] ain_reg, ain_next;
    logic [2:0]  ridx_reg, ridx_next;
    logic [15:0] wval_reg, wval_next;
    logic [15:0] pc_reg, pc_next;
    logic [2:0]  nzp_reg, nzp_next;
    logic        halt_reg, halt_next;
    logic [15:0] ir_reg, ir_next;
    logic [15:0] a_reg, a_next;
    logic [15:0] b_reg, b_next;
    logic [15:0] rdat_reg, rdat_next;
    logic [15:0] rf_reg [8];
    logic        ov_reg, ov_next;
    logic [15:0] ord_reg, ord_next;
    logic [15:0] opc_reg, opc_next;
    logic [2:0]  onzp_reg, onzp_next;
    logic        ohalt_reg, ohalt_next;

    logic [15:0] mem_addr;
    logic        mem_we;
    logic [15:0] mem_wdata;
    logic [15:0] mem_q;
    logic        rf_we;
    logic [2:0]  rf_wi;
    logic [15:0] rf_wd;
    logic [2:0]  rf_ri;
    logic [15:0] add_a, add_b, sum;
    logic [15:0] opb;
    logic [3:0]  opc;

    lc3_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_mem (
        .clk   (clk),
        .addr  (mem_addr[ADDR_BITS-1:0]),
        .we    (mem_we),
        .wdata (mem_wdata),
        .rdata (mem_q)
    );

    assign sum = add_a + add_b;
    assign opc = ir_reg[15:12];
    assign opb = ir_reg[5] ? lc3_pkg::sext5(ir_reg) : b_reg;

    assign req.ready     = (state_reg == lc3_pkg::ST_IDLE);
    assign rsp.valid     = ov_reg;
    assign rsp.read_data = ord_reg;
    assign rsp.pc_now    = opc_reg;
    assign rsp.flag_n    = onzp_reg[2];
    assign rsp.flag_z    = onzp_reg[1];
    assign rsp.flag_p    = onzp_reg[0];
    assign rsp.halt_seen = ohalt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lc3_pkg::ST_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= lc3_pkg::RESET_PC;
            nzp_reg   <= lc3_pkg::NZP_ZERO;
            halt_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < 8; i++)
                rf_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            nzp_reg   <= nzp_next;
            halt_reg  <= halt_next;
            ov_reg    <= ov_next;
            if (rf_we)
                rf_reg[rf_wi] <= rf_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        rt_reg    <= rt_next;
        ain_reg   <= ain_next;
        ridx_reg  <= ridx_next;
        wval_reg  <= wval_next;
        ir_reg    <= ir_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        rdat_reg  <= rdat_next;
        ord_reg   <= ord_next;
        opc_reg   <= opc_next;
        onzp_reg  <= onzp_next;
        ohalt_reg <= ohalt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        rt_next    = rt_reg;
        ain_next   = ain_reg;
        ridx_next  = ridx_reg;
        wval_next  = wval_reg;
        pc_next    = pc_reg;
        nzp_next   = nzp_reg;
        halt_next  = halt_reg;
        ir_next    = ir_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        rdat_next  = rdat_reg;
        ov_next    = ov_reg && !rsp.ready;
        ord_next   = ord_reg;
        opc_next   = opc_reg;
        onzp_next  = onzp_reg;
        ohalt_next = ohalt_reg;
        mem_addr   = pc_reg;
        mem_we     = 1'b0;
        mem_wdata  = wval_reg;
        rf_we      = 1'b0;
        rf_wi      = ridx_reg;
        rf_wd      = wval_reg;
        rf_ri      = ir_reg[8:6];
        add_a      = pc_reg;
        add_b      = lc3_pkg::sext9(ir_reg);

        unique case (state_reg)
            lc3_pkg::ST_CLEAR:
            begin
                mem_addr  = 16'(clr_reg);
                mem_we    = 1'b1;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                    state_next = lc3_pkg::ST_IDLE;
            end
            lc3_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    rt_next    = req.req_type;
                    ain_next   = req.address;
                    ridx_next  = req.reg_index;
                    wval_next  = req.write_value;
                    state_next = lc3_pkg::ST_START;
                end
            end
            lc3_pkg::ST_START:
            begin
                rdat_next  = '0;
                state_next = lc3_pkg::ST_DONE;
                case (rt_reg)
                    lc3_pkg::REQ_STEP:
                    begin
                        if (!halt_reg)
                        begin
                            mem_addr   = pc_reg;
                            add_b      = 16'd1;
                            pc_next    = sum;
                            state_next = lc3_pkg::ST_DECODE;
                        end
                    end
                    lc3_pkg::REQ_MEM_WR:
                    begin
                        mem_addr = ain_reg;
                        mem_we   = 1'b1;
                    end
                    lc3_pkg::REQ_MEM_RD:
                    begin
                        mem_addr   = ain_reg;
                        state_next = lc3_pkg::ST_LOAD;
                    end
                    lc3_pkg::REQ_REG_WR:
                    begin
                        rf_we    = 1'b1;
                        nzp_next = lc3_pkg::nzp_of(wval_reg);
                    end
                    lc3_pkg::REQ_PC_WR:
                        pc_next = wval_reg;
                    default:
                        state_next = lc3_pkg::ST_DONE;
                endcase
            end
            lc3_pkg::ST_DECODE:
            begin
                ir_next    = mem_q;
                state_next = lc3_pkg::ST_RDA;
            end
            lc3_pkg::ST_RDA:
            begin
                rf_ri      = ir_reg[8:6];
                a_next     = rf_reg[rf_ri];
                state_next = lc3_pkg::ST_RDB;
            end
            lc3_pkg::ST_RDB:
            begin
                case (opc)
                    lc3_pkg::OP_ST, lc3_pkg::OP_STR, lc3_pkg::OP_STI:
                        rf_ri = ir_reg[11:9];
                    lc3_pkg::OP_TRAP:
                        rf_ri = 3'd0;
                    default:
                        rf_ri = ir_reg[2:0];
                endcase
                b_next     = rf_reg[rf_ri];
                state_next = lc3_pkg::ST_EXEC;
            end
            lc3_pkg::ST_EXEC:
            begin
                state_next = lc3_pkg::ST_DONE;
                rf_wi      = ir_reg[11:9];
                case (opc)
                    lc3_pkg::OP_ADD:
                    begin
                        add_a = a_reg;
                        add_b = opb;
                    end
                    lc3_pkg::OP_LDR, lc3_pkg::OP_STR:
                    begin
                        add_a = a_reg;
                        add_b = lc3_pkg::sext6(ir_reg);
                    end
                    lc3_pkg::OP_JSR:
                        add_b = lc3_pkg::sext11(ir_reg);
                    default:
                    begin
                        add_a = pc_reg;
                        add_b = lc3_pkg::sext9(ir_reg);
                    end
                endcase
                unique case (opc)
                    lc3_pkg::OP_BR:
                    begin
                        if ((ir_reg[11:9] & nzp_reg) != 3'd0)
                            pc_next = sum;
                    end
                    lc3_pkg::OP_ADD, lc3_pkg::OP_LEA:
                    begin
                        rf_we    = 1'b1;
                        rf_wd    = sum;
                        nzp_next = lc3_pkg::nzp_of(sum);
                    end
                    lc3_pkg::OP_AND:
                    begin
                        rf_we    = 1'b1;
                        rf_wd    = a_reg & opb;
                        nzp_next = lc3_pkg::nzp_of(a_reg & opb);
                    end
                    lc3_pkg::OP_NOT:
                    begin
                        rf_we    = 1'b1;
                        rf_wd    = ~a_reg;
                        nzp_next = lc3_pkg::nzp_of(~a_reg);
                    end
                    lc3_pkg::OP_LD, lc3_pkg::OP_LDR, lc3_pkg::OP_LDI, lc3_pkg::OP_STI:
                    begin
                        mem_addr   = sum;
                        state_next = lc3_pkg::ST_LOAD;
                    end
                    lc3_pkg::OP_ST, lc3_pkg::OP_STR:
                    begin
                        mem_addr  = sum;
                        mem_we    = 1'b1;
                        mem_wdata = b_reg;
                    end
                    lc3_pkg::OP_JSR:
                    begin
                        rf_we   = 1'b1;
                        rf_wi   = 3'd7;
                        rf_wd   = pc_reg;
                        pc_next = ir_reg[11] ? sum : a_reg;
                    end
                    lc3_pkg::OP_JMP:
                        pc_next = a_reg;
                    lc3_pkg::OP_TRAP:
                    begin
                        rf_we = 1'b1;
                        rf_wi = 3'd7;
                        rf_wd = pc_reg;
                        case (ir_reg[7:0])
                            lc3_pkg::TRAP_GETC, lc3_pkg::TRAP_IN:
                            begin
                                mem_addr   = lc3_pkg::ADDR_KBD;
                                state_next = lc3_pkg::ST_LOAD;
                            end
                            lc3_pkg::TRAP_OUT:
                            begin
                                mem_addr  = lc3_pkg::ADDR_OUT;
                                mem_we    = 1'b1;
                                mem_wdata = {8'd0, b_reg[7:0]};
                            end
                            lc3_pkg::TRAP_PUTS:
                            begin
                                mem_addr  = lc3_pkg::ADDR_PUTS;
                                mem_we    = 1'b1;
                                mem_wdata = 16'd1;
                            end
                            default:
                                halt_next = 1'b1;
                        endcase
                    end
                    default:
                        halt_next = 1'b1;
                endcase
            end
            lc3_pkg::ST_LOAD:
            begin
                state_next = lc3_pkg::ST_DONE;
                rf_wi      = ir_reg[11:9];
                if (rt_reg == lc3_pkg::REQ_MEM_RD)
                    rdat_next = mem_q;
                else if (opc == lc3_pkg::OP_LDI)
                begin
                    mem_addr   = mem_q;
                    state_next = lc3_pkg::ST_LOAD2;
                end
                else if (opc == lc3_pkg::OP_STI)
                begin
                    mem_addr  = mem_q;
                    mem_we    = 1'b1;
                    mem_wdata = b_reg;
                end
                else if (opc == lc3_pkg::OP_TRAP)
                begin
                    rf_we    = 1'b1;
                    rf_wi    = 3'd0;
                    rf_wd    = {8'd0, mem_q[7:0]};
                    nzp_next = lc3_pkg::nzp_of({8'd0, mem_q[7:0]});
                end
                else
                begin
                    rf_we    = 1'b1;
                    rf_wd    = mem_q;
                    nzp_next = lc3_pkg::nzp_of(mem_q);
                end
            end
            lc3_pkg::ST_LOAD2:
            begin
                rf_we      = 1'b1;
                rf_wi      = ir_reg[11:9];
                rf_wd      = mem_q;
                nzp_next   = lc3_pkg::nzp_of(mem_q);
                state_next = lc3_pkg::ST_DONE;
            end
            lc3_pkg::ST_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    ord_next   = rdat_reg;
                    opc_next   = pc_reg;
                    onzp_next  = nzp_reg;
                    ohalt_next = halt_reg;
                    state_next = lc3_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lc3_pkg::ST_IDLE;
        endcase
    end

endmodule

[design/lc3_ram.sv]
// Generic single-port RAM with registered read.
module lc3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[addr] <= wdata;
        rdata <= mem_reg[addr];
    end

endmodule

[verif/lc3_core_checker.sv]
// Checker: predicts the LC-3 core response for each accepted request and compares it.
module lc3_core_checker
(
    input  logic clk,
    input  logic rst_n,
    lc3_req_if   req,
    lc3_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] read_data;
        logic [15:0] pc_now;
        logic        flag_n;
        logic        flag_z;
        logic        flag_p;
        logic        halt_seen;
    } core_view_t;

    logic [15:0] mem_model [logic [15:0]];
    logic [15:0] regs [8];
    logic [15:0] pc;
    logic [2:0]  nzp;
    logic        halted;
    core_view_t  due_q [$];

    function automatic logic [15:0] rd_word(logic [15:0] a);
        return mem_model.exists(a) ? mem_model[a] : 16'd0;
    endfunction

    function automatic logic [15:0] sx(logic [15:0] v, int bits);
        logic [15:0] r;
        r = v & ((16'd1 << bits) - 16'd1);
        if (r[bits-1])
            r = r | ~((16'd1 << bits) - 16'd1);
        return r;
    endfunction

    task automatic put_reg(logic [2:0] r, logic [15:0] v);
        regs[r] = v;
        nzp = v[15] ? 3'b100 : (v == 16'd0 ? 3'b010 : 3'b001);
    endtask

    task automatic run_instruction();
        logic [15:0] ins;
        logic [15:0] npc;
        logic [15:0] b;
        logic [15:0] tgt;
        logic [15:0] kbd;
        logic [2:0]  dr;
        logic [2:0]  sr;
        if (halted)
            return;
        ins = rd_word(pc);
        pc = pc + 16'd1;
        npc = pc;
        dr = ins[11:9];
        sr = ins[8:6];
        b = ins[5] ? sx(ins, 5) : regs[ins[2:0]];
        case (ins[15:12])
            lc3_pkg::OP_BR:  if (dr & nzp) pc = npc + sx(ins, 9);
            lc3_pkg::OP_ADD: put_reg(dr, regs[sr] + b);
            lc3_pkg::OP_LD:  put_reg(dr, rd_word(npc + sx(ins, 9)));
            lc3_pkg::OP_ST:  mem_model[npc + sx(ins, 9)] = regs[dr];
            lc3_pkg::OP_JSR:
            begin
                tgt = ins[11] ? npc + sx(ins, 11) : regs[sr];
                regs[7] = npc;
                pc = tgt;
            end
            lc3_pkg::OP_AND: put_reg(dr, regs[sr] & b);
            lc3_pkg::OP_LDR: put_reg(dr, rd_word(regs[sr] + sx(ins, 6)));
            lc3_pkg::OP_STR: mem_model[regs[sr] + sx(ins, 6)] = regs[dr];
            lc3_pkg::OP_NOT: put_reg(dr, ~regs[sr]);
            lc3_pkg::OP_LDI: put_reg(dr, rd_word(rd_word(npc + sx(ins, 9))));
            lc3_pkg::OP_STI: mem_model[rd_word(npc + sx(ins, 9))] = regs[dr];
            lc3_pkg::OP_JMP: pc = regs[sr];
            lc3_pkg::OP_LEA: put_reg(dr, npc + sx(ins, 9));
            lc3_pkg::OP_TRAP:
            begin
                regs[7] = pc;
                case (ins[7:0])
                    lc3_pkg::TRAP_GETC, lc3_pkg::TRAP_IN:
                    begin
                        kbd = rd_word(lc3_pkg::ADDR_KBD);
                        put_reg(3'd0, {8'd0, kbd[7:0]});
                    end
                    lc3_pkg::TRAP_OUT:  mem_model[lc3_pkg::ADDR_OUT] = {8'd0, regs[0][7:0]};
                    lc3_pkg::TRAP_PUTS: mem_model[lc3_pkg::ADDR_PUTS] = 16'd1;
                    default:   halted = 1'b1;
                endcase
            end
            default: halted = 1'b1;
        endcase
    endtask

    task automatic predict_core(logic [2:0] kind, logic [15:0] a, logic [2:0] r,
                                logic [15:0] v);
        core_view_t e;
        e.read_data = 16'd0;
        case (kind)
            lc3_pkg::REQ_STEP:   run_instruction();
            lc3_pkg::REQ_MEM_WR: mem_model[a] = v;
            lc3_pkg::REQ_MEM_RD: e.read_data = rd_word(a);
            lc3_pkg::REQ_REG_WR: put_reg(r, v);
            lc3_pkg::REQ_PC_WR:  pc = v;
            default: ;
        endcase
        e.pc_now = pc;
        {e.flag_n, e.flag_z, e.flag_p} = nzp;
        e.halt_seen = halted;
        due_q.push_back(e);
    endtask

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pc = lc3_pkg::RESET_PC;
        nzp = lc3_pkg::NZP_ZERO;
        halted = 1'b0;
        foreach (regs[i])
            regs[i] = 16'd0;
    end

    assign pending = due_q.size();

    always @(posedge clk)
    begin
        core_view_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (due_q.size() == 0)
                report("unexpected response", rsp.pc_now, 16'd0);
            else
            begin
                e = due_q.pop_front();
                if (rsp.read_data !== e.read_data) report("read_data", rsp.read_data, e.read_data);
                if (rsp.pc_now !== e.pc_now) report("pc_now", rsp.pc_now, e.pc_now);
                if (rsp.flag_n !== e.flag_n)
                    report("flag_n", {15'd0, rsp.flag_n}, {15'd0, e.flag_n});
                if (rsp.flag_z !== e.flag_z)
                    report("flag_z", {15'd0, rsp.flag_z}, {15'd0, e.flag_z});
                if (rsp.flag_p !== e.flag_p)
                    report("flag_p", {15'd0, rsp.flag_p}, {15'd0, e.flag_p});
                if (rsp.halt_seen !== e.halt_seen)
                    report("halt_seen", {15'd0, rsp.halt_seen}, {15'd0, e.halt_seen});
            end
        end
        if (rst_n && req.valid && req.ready)
            predict_core(req.req_type, req.address, req.reg_index, req.write_value);
    end
endmodule

[verif/tb_lc3_instruction_core_unit.sv]
// Testbench top: drives LC-3 core requests with varied idling and reports the verdict.
module tb_lc3_instruction_core_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle;
    int   stall_pct;
    int   hold_cycles;

    lc3_req_if req ();
    lc3_rsp_if rsp ();

    lc3_instruction_core_unit uut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));
    lc3_core_checker chk (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                          .fail_count(fail_count), .pending(pending));

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rsp.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp.ready <= 1'b0;
                hold_cycles--;
            end
            else
                rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send(logic [2:0] kind, logic [15:0] a, logic [2:0] r, logic [15:0] v);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.req_type <= kind;
        req.address <= a;
        req.reg_index <= r;
        req.write_value <= v;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    task automatic load_word(logic [15:0] a, logic [15:0] v);
        send(lc3_pkg::REQ_MEM_WR, a, 3'd0, v);
    endtask

    function automatic logic [15:0] rand_instr();
        logic [15:0] ins;
        ins = 16'($urandom);
        case ($urandom_range(19))
            0: ins[15:12] = lc3_pkg::OP_TRAP;
            1: ins = {lc3_pkg::OP_TRAP, 4'd0, 8'h20 + 8'($urandom_range(5))};
            2: ins[15:12] = 4'd8;
            3: ins[15:12] = 4'd13;
            default: ;
        endcase
        return ins;
    endfunction

    task automatic random_block(int n);
        logic [15:0] base;
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 8)
            begin
                base = 16'($urandom);
                if ($urandom_range(3) == 0)
                    base = 16'hFFFE;
                send(lc3_pkg::REQ_PC_WR, 16'd0, 3'd0, base);
                for (int j = 0; j < 4; j++)
                    load_word(base + 16'(j), rand_instr());
                send(lc3_pkg::REQ_REG_WR, 16'd0, 3'($urandom), 16'($urandom));
                send(lc3_pkg::REQ_STEP, 16'd0, 3'd0, 16'd0);
                send(lc3_pkg::REQ_STEP, 16'd0, 3'd0, 16'd0);
                i += 7;
            end
            else if (k < 12)
            begin
                send(lc3_pkg::REQ_PC_WR, 16'd0, 3'd0, 16'($urandom));
                send(lc3_pkg::REQ_MEM_WR, 16'hFFFD, 3'd0, 16'($urandom));
                i++;
            end
            else if (k < 14)
                send(3'($urandom_range(7, 5)), 16'($urandom), 3'($urandom), 16'($urandom));
            else if (k < 20)
                send(lc3_pkg::REQ_MEM_RD,
                     ($urandom_range(1) ? 16'(16'hFFFF - $urandom_range(3))
                                        : 16'($urandom)), 3'd0, 16'd0);
            else if (k < 30)
                send(lc3_pkg::REQ_REG_WR, 16'd0, 3'($urandom), 16'($urandom));
            else if (k < 35)
                send(lc3_pkg::REQ_MEM_WR, 16'($urandom), 3'd0, 16'($urandom));
            else
                send(lc3_pkg::REQ_STEP, 16'd0, 3'd0, 16'd0);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.req_type = lc3_pkg::REQ_STEP;
        req.address = 16'd0;
        req.reg_index = 3'd0;
        req.write_value = 16'd0;
        send_idle = 0;
        stall_pct = 0;
        hold_cycles = 0;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        send(lc3_pkg::REQ_STEP, 16'd0, 3'd0, 16'd0);
        send(lc3_pkg::REQ_REG_WR, 16'd0, 3'd1, 16'h7FFF);
        send(lc3_pkg::REQ_REG_WR, 16'd0, 3'd7, 16'h3005);
        send(lc3_pkg::REQ_REG_WR, 16'd0, 3'd2, 16'h8000);
        send(lc3_pkg::REQ_MEM_WR, 16'hFFFD, 3'd0, 16'hABCD);
        load_word(16'h3000, 16'h1261);
        load_word(16'h3001, 16'h5A3F);
        load_word(16'h3002, 16'h9EBF);
        load_word(16'h3003, 16'hF020);
        load_word(16'h3004, 16'hF021);
        load_word(16'h3005, 16'hF022);
        load_word(16'h3006, 16'h41C0);
        repeat (7) send(lc3_pkg::REQ_STEP, 16'd0, 3'd0, 16'd0);
        send(lc3_pkg::REQ_MEM_RD, 16'hFFFF, 3'd0, 16'd0);
        send(lc3_pkg::REQ_MEM_RD, 16'hFFFE, 3'd0, 16'd0);
        send(lc3_pkg::REQ_MEM_RD, 16'h0000, 3'd0, 16'd0);
        load_word(16'h3006, 16'hF025);
        send(lc3_pkg::REQ_STEP, 16'd0, 3'd0, 16'd0);
        send(lc3_pkg::REQ_STEP, 16'd0, 3'd0, 16'd0);
        send(lc3_pkg::REQ_PC_WR, 16'd0, 3'd0, 16'hFFFF);
        send(3'd7, 16'hFFFF, 3'd7, 16'hFFFF);
        drain();

        random_block(425);
        send_idle = 79;
        random_block(425);
        send_idle = 0;
        stall_pct = 79;
        random_block(425);
        hold_cycles = 300;
        random_block(40);
        send_idle = 22;
        stall_pct = 22;
        random_block(385);
        drain();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
